/* sv/assert_macros.svh */
// Assertion macros shared by the clamp-point-into-quad RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define CPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define CPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cpq_pkg.sv */
// Package: widths, types and codes of the clamp-point-into-quad pipeline.
`default_nettype none
package cpq_pkg;
    localparam int CPQ_W         = 24;
    localparam int DIFF_W        = CPQ_W + 1;
    localparam int PROD_W        = 2 * CPQ_W + 2;
    localparam int SUM_W         = 2 * CPQ_W + 3;
    localparam int DEN_W         = 2 * CPQ_W + 2;
    localparam int NUMU_W        = 2 * CPQ_W + 1;
    localparam int MAG_W         = CPQ_W + 1;
    localparam int Q_W           = CPQ_W + 1;
    localparam int DVS_W         = DEN_W + 1;
    localparam int REM_W         = 3 * CPQ_W + 3;
    localparam int DIST_W        = 2 * CPQ_W + 3;
    localparam int FRONT_STAGES  = 5;
    localparam int BACK_STAGES   = 4;
    localparam int DIV_STAGES    = Q_W;

    typedef logic signed [CPQ_W-1:0] t_coord;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_DIV
    } t_sel;

    typedef struct packed {
        logic           qv;
        logic           is_in;
        t_coord         px;
        t_coord         py;
        t_coord [3:0]   cx;
        t_coord [3:0]   cy;
        t_sel   [3:0]   sel;
        logic   [3:0]   negx;
        logic   [3:0]   negy;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [Q_W-1:0]   q;
    } t_lane;
endpackage
`default_nettype wire

/* sv/clamp_point_into_quad_top.sv */
// Top level: clamps a point into a quadrilateral through a fully pipelined datapath.
// One point enters and one result leaves per clock unless the output stalls; the stages
// are 5 front, 25 divider and 4 back (34 in all). The divider resolves one quotient
// bit per stage on eight lanes (x and y of each edge), and that chain sets the depth.
// Every stage holds its item independently, so a stalled output lets the pipeline fill
// its empty stages and keep taking input until all 34 are full.
`default_nettype none
`include "assert_macros.svh"
module clamp_point_into_quad_top import cpq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_quad_valid,
    input  t_coord i_point_x,
    input  t_coord i_point_y,
    input  t_coord i_corner0_x,
    input  t_coord i_corner0_y,
    input  t_coord i_corner1_x,
    input  t_coord i_corner1_y,
    input  t_coord i_corner2_x,
    input  t_coord i_corner2_y,
    input  t_coord i_corner3_x,
    input  t_coord i_corner3_y,
    output logic   o_valid,
    input  logic   i_ready,
    output t_coord o_clamped_x,
    output t_coord o_clamped_y,
    output logic   o_was_inside
);
    localparam int DEPTH = FRONT_STAGES + DIV_STAGES + BACK_STAGES;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_coord [3:0] w_cx, w_cy;
    t_side        w_side  [DIV_STAGES+1];
    t_lane [7:0]  w_lanes [DIV_STAGES+1];
    logic         w_v     [DIV_STAGES+1];
    logic         w_rdy   [DIV_STAGES+1];

    assign w_cx = {i_corner3_x, i_corner2_x, i_corner1_x, i_corner0_x};
    assign w_cy = {i_corner3_y, i_corner2_y, i_corner1_y, i_corner0_y};

    cpq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_qv    (i_quad_valid),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_cx    (w_cx),
        .i_cy    (w_cy),
        .o_valid (w_v[0]),
        .i_ready (w_rdy[0]),
        .o_side  (w_side[0]),
        .o_lanes (w_lanes[0])
    );

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        cpq_div_stage #(
            .BIT (Q_W - 1 - k)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_side  (w_side[k]),
            .i_lanes (w_lanes[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_side  (w_side[k+1]),
            .o_lanes (w_lanes[k+1])
        );
    end

    cpq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_v[DIV_STAGES]),
        .o_ready      (w_rdy[DIV_STAGES]),
        .i_side       (w_side[DIV_STAGES]),
        .i_lanes      (w_lanes[DIV_STAGES]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_clamped_x  (o_clamped_x),
        .o_clamped_y  (o_clamped_y),
        .o_was_inside (o_was_inside)
    );

    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    always_comb begin
        n_inflight = r_inflight;
        if (i_valid && o_ready) begin
            n_inflight = n_inflight + CNT_W'(1);
        end
        if (o_valid && i_ready) begin
            n_inflight = n_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `CPQ_ASSERT_IMPL(a_depth_bound, 1'b1, r_inflight <= CNT_W'(DEPTH), "more transfers in flight than stages")
    `CPQ_ASSERT_IMPL(a_no_phantom, r_inflight == '0, !o_valid, "result without a pending transfer")
endmodule
`default_nettype wire

/* sv/cpq_front.sv */
// Front pipeline: edge differences, products, containment test and divider setup.
`default_nettype none
`include "assert_macros.svh"
module cpq_front import cpq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_qv,
    input  t_coord        i_px,
    input  t_coord        i_py,
    input  t_coord [3:0]  i_cx,
    input  t_coord [3:0]  i_cy,
    output logic          o_valid,
    input  logic          i_ready,
    output t_side         o_side,
    output t_lane [7:0]   o_lanes
);
    logic [FRONT_STAGES-1:0] r_v;
    logic [FRONT_STAGES-1:0] adv;

    always_comb begin
        adv[FRONT_STAGES-1] = !r_v[FRONT_STAGES-1] || i_ready;
        for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < FRONT_STAGES; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[FRONT_STAGES-1];

    // stage 1: differences
    logic signed [DIFF_W-1:0] n1_abx [4], n1_aby [4], n1_pax [4], n1_pay [4];
    logic signed [DIFF_W-1:0] n1_pcx [4], n1_dyc [4], n1_exc [4], n1_eyc [4];
    logic [3:0]               n1_str;
    t_side                    n1_s;
    logic signed [DIFF_W-1:0] r1_abx [4], r1_aby [4], r1_pax [4], r1_pay [4];
    logic signed [DIFF_W-1:0] r1_pcx [4], r1_dyc [4], r1_exc [4], r1_eyc [4];
    logic [3:0]               r1_str;
    t_side                    r1_s;

    always_comb begin
        n1_s        = '0;
        n1_s.qv     = i_qv;
        n1_s.px     = i_px;
        n1_s.py     = i_py;
        n1_s.cx     = i_cx;
        n1_s.cy     = i_cy;
        for (int e = 0; e < 4; e++) begin
            n1_abx[e] = $signed(i_cx[2'(e + 1)]) - $signed(i_cx[e]);
            n1_aby[e] = $signed(i_cy[2'(e + 1)]) - $signed(i_cy[e]);
            n1_pax[e] = $signed(i_px) - $signed(i_cx[e]);
            n1_pay[e] = $signed(i_py) - $signed(i_cy[e]);
            n1_pcx[e] = $signed(i_px) - $signed(i_cx[e]);
            n1_dyc[e] = $signed(i_cy[2'(e + 3)]) - $signed(i_cy[e]);
            n1_exc[e] = $signed(i_cx[2'(e + 3)]) - $signed(i_cx[e]);
            n1_eyc[e] = $signed(i_py) - $signed(i_cy[e]);
            n1_str[e] = ($signed(i_cy[e]) > $signed(i_py))
                     != ($signed(i_cy[2'(e + 3)]) > $signed(i_py));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_abx <= n1_abx;
            r1_aby <= n1_aby;
            r1_pax <= n1_pax;
            r1_pay <= n1_pay;
            r1_pcx <= n1_pcx;
            r1_dyc <= n1_dyc;
            r1_exc <= n1_exc;
            r1_eyc <= n1_eyc;
            r1_str <= n1_str;
            r1_s   <= n1_s;
        end
    end

    // stage 2: products
    logic signed [PROD_W-1:0] n2_xx [4], n2_yy [4], n2_nx [4], n2_ny [4];
    logic signed [PROD_W-1:0] n2_lhs [4], n2_rhs [4];
    logic [MAG_W-1:0]         n2_mx [4], n2_my [4];
    logic [3:0]               n2_dpos;
    t_side                    n2_s;
    logic signed [PROD_W-1:0] r2_xx [4], r2_yy [4], r2_nx [4], r2_ny [4];
    logic signed [PROD_W-1:0] r2_lhs [4], r2_rhs [4];
    logic [MAG_W-1:0]         r2_mx [4], r2_my [4];
    logic [3:0]               r2_dpos;
    logic [3:0]               r2_str;
    t_side                    r2_s;

    always_comb begin
        n2_s = r1_s;
        for (int e = 0; e < 4; e++) begin
            n2_xx[e]     = r1_abx[e] * r1_abx[e];
            n2_yy[e]     = r1_aby[e] * r1_aby[e];
            n2_nx[e]     = r1_pax[e] * r1_abx[e];
            n2_ny[e]     = r1_pay[e] * r1_aby[e];
            n2_lhs[e]    = r1_pcx[e] * r1_dyc[e];
            n2_rhs[e]    = r1_exc[e] * r1_eyc[e];
            n2_dpos[e]   = r1_dyc[e] > 0;
            n2_s.negx[e] = r1_abx[e][DIFF_W-1];
            n2_s.negy[e] = r1_aby[e][DIFF_W-1];
            n2_mx[e]     = r1_abx[e][DIFF_W-1] ? MAG_W'(-r1_abx[e]) : MAG_W'(r1_abx[e]);
            n2_my[e]     = r1_aby[e][DIFF_W-1] ? MAG_W'(-r1_aby[e]) : MAG_W'(r1_aby[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_xx   <= n2_xx;
            r2_yy   <= n2_yy;
            r2_nx   <= n2_nx;
            r2_ny   <= n2_ny;
            r2_lhs  <= n2_lhs;
            r2_rhs  <= n2_rhs;
            r2_mx   <= n2_mx;
            r2_my   <= n2_my;
            r2_dpos <= n2_dpos;
            r2_str  <= r1_str;
            r2_s    <= n2_s;
        end
    end

    // stage 3: sums, classification, crossing parity
    logic [DEN_W-1:0]  n3_den [4];
    logic [NUMU_W-1:0] n3_num [4];
    t_side             n3_s;
    logic [DEN_W-1:0]  r3_den [4];
    logic [NUMU_W-1:0] r3_num [4];
    logic [MAG_W-1:0]  r3_mx [4], r3_my [4];
    t_side             r3_s;

    always_comb begin
        logic signed [SUM_W-1:0] dsum;
        logic signed [SUM_W-1:0] nsum;
        logic                    acc;
        n3_s = r2_s;
        acc  = 1'b0;
        for (int e = 0; e < 4; e++) begin
            dsum      = SUM_W'(r2_xx[e]) + SUM_W'(r2_yy[e]);
            nsum      = SUM_W'(r2_nx[e]) + SUM_W'(r2_ny[e]);
            n3_den[e] = dsum[DEN_W-1:0];
            n3_num[e] = nsum[NUMU_W-1:0];
            if (dsum == 0 || nsum <= 0) begin
                n3_s.sel[e] = SEL_A;
            end else if (nsum >= dsum) begin
                n3_s.sel[e] = SEL_B;
            end else begin
                n3_s.sel[e] = SEL_DIV;
            end
            if (r2_str[e] && (r2_dpos[e] ? (r2_lhs[e] < r2_rhs[e])
                                         : (r2_rhs[e] < r2_lhs[e]))) begin
                acc = !acc;
            end
        end
        n3_s.is_in = acc;
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_den <= n3_den;
            r3_num <= n3_num;
            r3_mx  <= r2_mx;
            r3_my  <= r2_my;
            r3_s   <= n3_s;
        end
    end

    // stage 4: magnitude times numerator, split in two partial products
    logic [PROD_W-1:0]  n4_plx [4], n4_ply [4];
    logic [2*CPQ_W:0]   n4_phx [4], n4_phy [4];
    logic [PROD_W-1:0]  r4_plx [4], r4_ply [4];
    logic [2*CPQ_W:0]   r4_phx [4], r4_phy [4];
    logic [DEN_W-1:0]   r4_den [4];
    t_side              r4_s;

    always_comb begin
        for (int e = 0; e < 4; e++) begin
            n4_plx[e] = r3_mx[e] * r3_num[e][CPQ_W:0];
            n4_ply[e] = r3_my[e] * r3_num[e][CPQ_W:0];
            n4_phx[e] = r3_mx[e] * r3_num[e][NUMU_W-1:CPQ_W+1];
            n4_phy[e] = r3_my[e] * r3_num[e][NUMU_W-1:CPQ_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_plx <= n4_plx;
            r4_ply <= n4_ply;
            r4_phx <= n4_phx;
            r4_phy <= n4_phy;
            r4_den <= r3_den;
            r4_s   <= r3_s;
        end
    end

    // stage 5: dividend and divisor for round-half-up quotient
    t_lane [7:0] n5_lanes;
    t_lane [7:0] r5_lanes;
    t_side       r5_s;

    always_comb begin
        for (int e = 0; e < 4; e++) begin
            n5_lanes[2*e].rem   = (((REM_W'(r4_phx[e]) << MAG_W) + REM_W'(r4_plx[e])) << 1)
                                + REM_W'(r4_den[e]);
            n5_lanes[2*e+1].rem = (((REM_W'(r4_phy[e]) << MAG_W) + REM_W'(r4_ply[e])) << 1)
                                + REM_W'(r4_den[e]);
            n5_lanes[2*e].dvs   = {r4_den[e], 1'b0};
            n5_lanes[2*e+1].dvs = {r4_den[e], 1'b0};
            n5_lanes[2*e].q     = '0;
            n5_lanes[2*e+1].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r5_lanes <= n5_lanes;
            r5_s     <= r4_s;
        end
    end

    assign o_side  = r5_s;
    assign o_lanes = r5_lanes;

    `CPQ_ASSERT_NEXT(a_front_load, i_valid && o_ready, r_v[0], "accepted transfer not loaded")
endmodule
`default_nettype wire

/* sv/cpq_div_stage.sv */
// One restoring-division stage: resolves one quotient bit on all eight lanes.
`default_nettype none
module cpq_div_stage import cpq_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_side        i_side,
    input  t_lane [7:0]  i_lanes,
    output logic         o_valid,
    input  logic         i_ready,
    output t_side        o_side,
    output t_lane [7:0]  o_lanes
);
    logic        r_v;
    logic        adv;
    t_lane [7:0] n_lanes;
    t_lane [7:0] r_lanes;
    t_side       r_side;

    assign adv     = !r_v || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v;

    always_comb begin
        logic [REM_W-1:0] sh;
        n_lanes = i_lanes;
        for (int l = 0; l < 8; l++) begin
            sh = REM_W'(i_lanes[l].dvs) << BIT;
            if (i_lanes[l].rem >= sh) begin
                n_lanes[l].rem    = i_lanes[l].rem - sh;
                n_lanes[l].q[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lanes <= n_lanes;
            r_side  <= i_side;
        end
    end

    assign o_side  = r_side;
    assign o_lanes = r_lanes;
endmodule
`default_nettype wire

/* sv/cpq_back.sv */
// Back pipeline: edge candidates, squared distances, nearest pick and output register.
`default_nettype none
module cpq_back import cpq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_side        i_side,
    input  t_lane [7:0]  i_lanes,
    output logic         o_valid,
    input  logic         i_ready,
    output t_coord       o_clamped_x,
    output t_coord       o_clamped_y,
    output logic         o_was_inside
);
    logic [BACK_STAGES-1:0] r_v;
    logic [BACK_STAGES-1:0] adv;

    always_comb begin
        adv[BACK_STAGES-1] = !r_v[BACK_STAGES-1] || i_ready;
        for (int k = BACK_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < BACK_STAGES; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[BACK_STAGES-1];

    // stage 1: candidate on each edge
    t_coord n1_cx [4], n1_cy [4];
    t_coord r1_cx [4], r1_cy [4];
    t_side  r1_s;

    always_comb begin
        logic signed [CPQ_W+1:0] offx;
        logic signed [CPQ_W+1:0] offy;
        logic signed [CPQ_W+1:0] sumx;
        logic signed [CPQ_W+1:0] sumy;
        for (int e = 0; e < 4; e++) begin
            offx = i_side.negx[e] ? -$signed({1'b0, i_lanes[2*e].q})
                                  :  $signed({1'b0, i_lanes[2*e].q});
            offy = i_side.negy[e] ? -$signed({1'b0, i_lanes[2*e+1].q})
                                  :  $signed({1'b0, i_lanes[2*e+1].q});
            sumx = $signed(i_side.cx[e]) + offx;
            sumy = $signed(i_side.cy[e]) + offy;
            unique case (i_side.sel[e])
                SEL_A: begin
                    n1_cx[e] = i_side.cx[e];
                    n1_cy[e] = i_side.cy[e];
                end
                SEL_B: begin
                    n1_cx[e] = i_side.cx[2'(e + 1)];
                    n1_cy[e] = i_side.cy[2'(e + 1)];
                end
                SEL_DIV: begin
                    n1_cx[e] = sumx[CPQ_W-1:0];
                    n1_cy[e] = sumy[CPQ_W-1:0];
                end
                default: begin
                    n1_cx[e] = i_side.cx[e];
                    n1_cy[e] = i_side.cy[e];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_cx <= n1_cx;
            r1_cy <= n1_cy;
            r1_s  <= i_side;
        end
    end

    // stage 2: squared offsets
    logic [PROD_W-1:0] n2_sx [4], n2_sy [4];
    logic [PROD_W-1:0] r2_sx [4], r2_sy [4];
    t_coord            r2_cx [4], r2_cy [4];
    t_side             r2_s;

    always_comb begin
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [PROD_W-1:0] px2;
        logic signed [PROD_W-1:0] py2;
        for (int e = 0; e < 4; e++) begin
            dx       = $signed(r1_cx[e]) - $signed(r1_s.px);
            dy       = $signed(r1_cy[e]) - $signed(r1_s.py);
            px2      = dx * dx;
            py2      = dy * dy;
            n2_sx[e] = px2;
            n2_sy[e] = py2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_sx <= n2_sx;
            r2_sy <= n2_sy;
            r2_cx <= r1_cx;
            r2_cy <= r1_cy;
            r2_s  <= r1_s;
        end
    end

    // stage 3: distances and pairwise pick, earlier edge wins ties
    logic [DIST_W-1:0] n3_d [2];
    t_coord            n3_x [2], n3_y [2];
    logic [DIST_W-1:0] r3_d [2];
    t_coord            r3_x [2], r3_y [2];
    t_side             r3_s;

    always_comb begin
        logic [DIST_W-1:0] edist [4];
        for (int e = 0; e < 4; e++) begin
            edist[e] = DIST_W'(r2_sx[e]) + DIST_W'(r2_sy[e]);
        end
        for (int p = 0; p < 2; p++) begin
            if (edist[2*p+1] < edist[2*p]) begin
                n3_d[p] = edist[2*p+1];
                n3_x[p] = r2_cx[2*p+1];
                n3_y[p] = r2_cy[2*p+1];
            end else begin
                n3_d[p] = edist[2*p];
                n3_x[p] = r2_cx[2*p];
                n3_y[p] = r2_cy[2*p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_d <= n3_d;
            r3_x <= n3_x;
            r3_y <= n3_y;
            r3_s <= r2_s;
        end
    end

    // stage 4: final pick and output register
    t_coord n4_x, n4_y;
    logic   n4_in;
    t_coord r4_x, r4_y;
    logic   r4_in;

    always_comb begin
        n4_in = !r3_s.qv || r3_s.is_in;
        if (n4_in) begin
            n4_x = r3_s.px;
            n4_y = r3_s.py;
        end else if (r3_d[1] < r3_d[0]) begin
            n4_x = r3_x[1];
            n4_y = r3_y[1];
        end else begin
            n4_x = r3_x[0];
            n4_y = r3_y[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_x  <= n4_x;
            r4_y  <= n4_y;
            r4_in <= n4_in;
        end
    end

    assign o_clamped_x  = r4_x;
    assign o_clamped_y  = r4_y;
    assign o_was_inside = r4_in;
endmodule
`default_nettype wire
